@@ rtl/core/disk_transfer_bounds_check_defines.svh @@
// ----------------------------------------------------------------------------
// Disk transfer bounds check assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef DISK_TRANSFER_BOUNDS_CHECK_DEFINES_SVH
`define DISK_TRANSFER_BOUNDS_CHECK_DEFINES_SVH

// Same-cycle implication.
`define DTBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dtbc assertion failed");

// Next-cycle implication.
`define DTBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dtbc assertion failed");

`endif

@@ rtl/core/dtbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Disk transfer bounds check package
// Status codes, widths and the word types carried along the divider chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtbc_pkg;

  localparam int unsigned CNT_W = 24;
  localparam int unsigned SEC_W = 32;
  localparam int unsigned DIV_W = 16;
  // The absolute sector is a 31-bit block plus a 32-bit offset.
  localparam int unsigned DVD_W = SEC_W + 1;

  typedef enum logic [1:0] {
    ST_PROCEED = 2'd0,
    ST_EOP     = 2'd1,
    ST_ROFS    = 2'd2,
    ST_INVAL   = 2'd3
  } status_e;

  typedef enum logic {
    REG_SPC   = 1'b0,
    REG_LABEL = 1'b1
  } reg_idx_e;

  // Check results that ride along with the division.
  typedef struct packed {
    status_e            status;
    logic [CNT_W-1:0]   xfer;
    logic [CNT_W-1:0]   resid;
  } side_t;

  // One word of the divider chain.
  typedef struct packed {
    side_t              side;
    logic [DIV_W-1:0]   dvs;
    logic [DIV_W-1:0]   rem;
    logic [DVD_W-1:0]   w;
  } cell_t;

endpackage

@@ rtl/core/dtbc_check.sv @@
// ----------------------------------------------------------------------------
// Disk transfer bounds check, request classifier
// Decides status, transfer and residual and forms the dividend for a request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtbc_check #(
  parameter int unsigned LABEL_SECTOR = 0,
  parameter int unsigned BLOCK_SHIFT  = 9
) (
  input  logic [31:0]               block_number_i,
  input  logic [dtbc_pkg::CNT_W-1:0] byte_count_i,
  input  logic [31:0]               partition_offset_i,
  input  logic [31:0]               partition_size_i,
  input  logic                      is_read_i,
  input  logic                      label_write_ok_i,
  input  logic [15:0]               spc_i,
  input  logic [31:0]               label_base_i,
  output dtbc_pkg::cell_t           cell_o
);

  localparam int unsigned DW = dtbc_pkg::DVD_W;
  localparam int unsigned RW = dtbc_pkg::CNT_W + 1;

  logic            neg;
  logic [DW-1:0]   blk;
  logic [DW-1:0]   size;
  logic [DW-1:0]   sum;
  logic [DW-1:0]   label_lim;
  logic [RW-1:0]   cnt_round;
  logic [RW-1:0]   nblk;
  logic [DW-1:0]   need;
  logic [DW-1:0]   fit;
  logic            ro;
  logic            over;
  logic [dtbc_pkg::CNT_W-1:0] xfer;
  dtbc_pkg::status_e status;

  assign neg       = block_number_i[31];
  assign blk       = {1'b0, block_number_i};
  assign size      = {1'b0, partition_size_i};
  assign sum       = blk + {1'b0, partition_offset_i};
  assign label_lim = DW'(LABEL_SECTOR) + {1'b0, label_base_i};
  assign cnt_round = {1'b0, byte_count_i} + RW'((1 << BLOCK_SHIFT) - 1);
  assign nblk      = cnt_round >> BLOCK_SHIFT;
  assign need      = blk + DW'(nblk);
  assign fit       = size - blk;
  assign ro        = (sum <= label_lim) && !is_read_i && !label_write_ok_i;
  assign over      = need > size;

  always_comb begin
    status = dtbc_pkg::ST_PROCEED;
    xfer   = byte_count_i;
    if (neg) begin
      status = dtbc_pkg::ST_INVAL;
    end else if (ro) begin
      status = dtbc_pkg::ST_ROFS;
    end else if (over) begin
      if (blk == size) begin
        status = dtbc_pkg::ST_EOP;
      end else if (size < blk) begin
        status = dtbc_pkg::ST_INVAL;
      end else begin
        xfer = dtbc_pkg::CNT_W'(fit << BLOCK_SHIFT);
      end
    end
  end

  always_comb begin
    cell_o.side.status = status;
    if (status == dtbc_pkg::ST_PROCEED) begin
      cell_o.side.xfer  = xfer;
      cell_o.side.resid = byte_count_i - xfer;
    end else begin
      cell_o.side.xfer  = '0;
      cell_o.side.resid = byte_count_i;
    end
    cell_o.dvs = (spc_i == '0) ? dtbc_pkg::DIV_W'(1) : spc_i;
    cell_o.rem = '0;
    cell_o.w   = sum;
  end

endmodule

@@ rtl/core/dtbc_div_cell.sv @@
// ----------------------------------------------------------------------------
// Disk transfer bounds check, divider cell
// One restoring division step with its own register and flow control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "disk_transfer_bounds_check_defines.svh"

module dtbc_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            up_valid_i,
  input  dtbc_pkg::cell_t up_i,
  output logic            up_ready_o,
  input  logic            dn_ready_i,
  output logic            q_valid_o,
  output dtbc_pkg::cell_t q_o
);

  localparam int unsigned DW = dtbc_pkg::DVD_W;
  localparam int unsigned VW = dtbc_pkg::DIV_W;

  logic                 valid_q;
  dtbc_pkg::cell_t      data_q;
  dtbc_pkg::cell_t      data_d;
  logic [VW:0]          trial;
  logic [VW:0]          diff;
  logic                 ge;

  // Shift the next dividend bit into the remainder and try the subtraction;
  // the quotient bit fills the low end of the dividend word.
  assign trial = {up_i.rem, up_i.w[DW-1]};
  assign diff  = trial - {1'b0, up_i.dvs};
  assign ge    = trial >= {1'b0, up_i.dvs};

  always_comb begin
    data_d     = up_i;
    data_d.rem = ge ? diff[VW-1:0] : trial[VW-1:0];
    data_d.w   = {up_i.w[DW-2:0], ge};
  end

  assign up_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= data_d;
    end
  end

  assign q_valid_o = valid_q;
  assign q_o       = data_q;

  `DTBC_ASSERT_NOW(a_rem_below_dvs, valid_q, data_q.rem < data_q.dvs)
  `DTBC_ASSERT_NOW(a_dvs_nonzero, valid_q, data_q.dvs != '0)
  `DTBC_ASSERT_NEXT(a_hold_on_stall, valid_q && !dn_ready_i, valid_q && $stable(data_q))

endmodule

@@ rtl/core/disk_transfer_bounds_check.sv @@
// ----------------------------------------------------------------------------
// Disk transfer bounds check
// Partition range and label protection check with a pipelined cylinder divide.
// ----------------------------------------------------------------------------
// Requests enter on the input channel (in_valid_i / in_stall_o) and one result
// word leaves on the output channel (out_valid_o / out_stall_i) per request, in
// order. A word moves at an edge where valid is high and stall is low.
// The classifier settles status, transfer and residual as the request enters.
// The cylinder number is then formed by a chain of 33 divider cells, one
// quotient bit per cell, so a result leaves after its request has passed the
// register of every cell. One request can enter every cycle while the output
// is not stalled; the chain holds up to 33 requests in flight.
// Each cell holds its word while the cell after it is full and not moving, so
// a stalled receiver fills the chain from the output end back; empty cells
// keep accepting until the chain is full, and only then is in_stall_o raised.
// Reset empties the chain and sets sectors per cylinder to 1 and the label
// base sector to 0. Configuration writes go through cfg_we_i, cfg_idx_i and
// cfg_data_i and should only be made while no request is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "disk_transfer_bounds_check_defines.svh"

module disk_transfer_bounds_check #(
  parameter int unsigned LABEL_SECTOR = 0,
  parameter int unsigned BLOCK_SHIFT  = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // Request channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [31:0] block_number_i,
  input  logic [23:0] byte_count_i,
  input  logic [31:0] partition_offset_i,
  input  logic [31:0] partition_size_i,
  input  logic        is_read_i,
  input  logic        label_write_ok_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [23:0] transfer_bytes_o,
  output logic [23:0] residual_bytes_o,
  output logic [31:0] cylinder_o
);

  localparam int unsigned NCELL = dtbc_pkg::DVD_W;

  logic [15:0]     spc_q;
  logic [31:0]     label_base_q;

  dtbc_pkg::cell_t stage [0:NCELL];
  logic            valid [0:NCELL];
  logic            ready [0:NCELL];
  dtbc_pkg::cell_t last;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_q        <= 16'd1;
      label_base_q <= '0;
    end else if (cfg_we_i) begin
      unique case (dtbc_pkg::reg_idx_e'(cfg_idx_i))
        dtbc_pkg::REG_SPC:   spc_q        <= cfg_data_i[15:0];
        dtbc_pkg::REG_LABEL: label_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The classifier feeds the head of the chain directly from the ports.
  dtbc_check #(
    .LABEL_SECTOR(LABEL_SECTOR),
    .BLOCK_SHIFT (BLOCK_SHIFT)
  ) u_check (
    .block_number_i    (block_number_i),
    .byte_count_i      (byte_count_i),
    .partition_offset_i(partition_offset_i),
    .partition_size_i  (partition_size_i),
    .is_read_i         (is_read_i),
    .label_write_ok_i  (label_write_ok_i),
    .spc_i             (spc_q),
    .label_base_i      (label_base_q),
    .cell_o            (stage[0])
  );

  assign valid[0]     = in_valid_i;
  assign in_stall_o   = !ready[0];
  assign ready[NCELL] = !out_stall_i;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    dtbc_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .up_valid_i(valid[k]),
      .up_i      (stage[k]),
      .up_ready_o(ready[k]),
      .dn_ready_i(ready[k+1]),
      .q_valid_o (valid[k+1]),
      .q_o       (stage[k+1])
    );
  end

  // After the last cell the dividend word holds the full quotient; a quotient
  // past 32 bits saturates, and refused requests report cylinder zero.
  assign last             = stage[NCELL];
  assign out_valid_o      = valid[NCELL];
  assign status_o         = last.side.status;
  assign transfer_bytes_o = last.side.xfer;
  assign residual_bytes_o = last.side.resid;

  always_comb begin
    if (last.side.status != dtbc_pkg::ST_PROCEED) begin
      cylinder_o = '0;
    end else if (last.w[NCELL-1]) begin
      cylinder_o = '1;
    end else begin
      cylinder_o = last.w[31:0];
    end
  end

  `DTBC_ASSERT_NOW(a_empty_out_takes_in, !out_valid_o, !in_stall_o)
  `DTBC_ASSERT_NOW(a_proceed_no_loss,
      out_valid_o && status_o == dtbc_pkg::ST_PROCEED,
      transfer_bytes_o != '0 || residual_bytes_o == '0)

endmodule
